// ===== rtl/core/bmm_pkg.sv =====
// Shared types and constants for the bipartite matching engine.
package bmm_pkg;

  localparam int VERTEX_LIMIT_DEF = 63;
  localparam logic [4:0] COUNT_MAX = 5'd31;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_RUN   = 2'd2,
    FUNC_NONE  = 2'd3
  } bmm_func_t;

  typedef struct packed {
    bmm_func_t  func;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
  } bmm_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_RA, S_ADD_WA, S_ADD_RB, S_ADD_WB,
    S_RUN_INIT, S_L_START, S_L_INIT_RD, S_L_INIT_WR, S_L_DIST0,
    S_L_POP, S_L_POPD, S_L_ROW, S_L_SCAN, S_L_PW, S_L_DW,
    S_A_NEXT, S_A_CHK, S_A_LOAD, S_A_ROW, S_A_SCAN, S_A_PW, S_A_DW,
    S_A_FAIL, S_A_POPD, S_A_FLIP0, S_A_FLIP1, S_A_FLIPD,
    S_EMIT
  } bmm_state_t;

endpackage

// ===== rtl/core/bmm_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module bmm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bmm_engine.sv =====
// Graph storage and the layered search sequencer built around the state memories.
module bmm_engine
  import bmm_pkg::*;
#(
  parameter int VERTEX_LIMIT = VERTEX_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  bmm_req_t   req,
  input  logic [5:0] vertex_count,
  input  logic       out_free,
  output logic       idle,
  output logic       result_vld,
  output logic [4:0] result
);

  localparam int DEPTH = VERTEX_LIMIT + 1;
  localparam int VW    = $clog2(DEPTH);
  localparam int CW    = (VW + 1 > 6) ? VW + 1 : 6;
  localparam int DW    = (VERTEX_LIMIT < 127) ? 7 : 11;
  localparam logic [DW-1:0] DIST_INF = {DW{1'b1}};
  localparam logic [VW:0]   LIM_V    = (VW+1)'(VERTEX_LIMIT);

  bmm_state_t state_r, state_nxt;

  logic [VW:0]     i_r, i_nxt, v_r, v_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [VW:0]     cur_next_r, cur_next_nxt;
  logic [VW-1:0]   top_r, top_nxt, cur_u_r, cur_u_nxt, w_r, w_nxt;
  logic [VW-1:0]   a_r, a_nxt, b_r, b_nxt;
  logic [DEPTH-1:0] row_r, row_nxt;
  logic [DW-1:0]   du_r, du_nxt;
  logic [DW:0]     want_r, want_nxt;
  logic            dist0_inf_r, dist0_inf_nxt, gained_r, gained_nxt;
  logic [4:0]      count_r, count_nxt;
  logic [DEPTH-1:0] adj_vld_r, adj_vld_nxt, par_vld_r, par_vld_nxt;
  logic            adj_rv_r, par_rv_r;

  // memory ports
  logic             adj_we, par_we, dist_we, q_we, st_we;
  logic [VW-1:0]    adj_wa, adj_ra, par_wa, par_ra, dist_wa, dist_ra;
  logic [VW-1:0]    q_wa, q_ra, st_wa, st_ra;
  logic [DEPTH-1:0] adj_wd, adj_rd, adj_q;
  logic [VW-1:0]    par_wd, par_rd, par_q, q_wd, q_rd;
  logic [DW-1:0]    dist_wd, dist_rd;
  logic [2*VW-1:0]  st_wd, st_rd;

  // effective vertex count
  logic [CW-1:0] vc_ext, a_ext, b_ext, n_ext;
  logic [VW:0]   n;
  logic          add_ok;

  assign vc_ext = CW'(vertex_count);
  assign a_ext  = CW'(req.vertex_a);
  assign b_ext  = CW'(req.vertex_b);
  assign n_ext  = (vc_ext > CW'(VERTEX_LIMIT)) ? CW'(VERTEX_LIMIT) : vc_ext;
  assign n      = n_ext[VW:0];
  assign add_ok = (a_ext != '0) && (b_ext != '0) && (a_ext <= n_ext) &&
                  (b_ext <= n_ext) && (a_ext != b_ext);

  assign adj_q = adj_rv_r ? adj_rd : '0;
  assign par_q = par_rv_r ? par_rd : '0;

  logic i_gt_n, v_gt_n, row_bit, head_eq_tail, top_zero, dist_hit, can_push;
  assign i_gt_n       = i_r > n;
  assign v_gt_n       = v_r > n;
  assign row_bit      = row_r[v_r[VW-1:0]];
  assign head_eq_tail = head_r == tail_r;
  assign top_zero     = top_r == '0;
  assign dist_hit     = {1'b0, dist_rd} == want_r;
  assign can_push     = ({1'b0, top_r} + 1'b1) <= LIM_V;

  bmm_ram #(.DEPTH(DEPTH), .WIDTH(DEPTH), .AW(VW)) u_adj (
    .clk, .we(adj_we), .waddr(adj_wa), .wdata(adj_wd), .raddr(adj_ra), .rdata(adj_rd));
  bmm_ram #(.DEPTH(DEPTH), .WIDTH(VW), .AW(VW)) u_par (
    .clk, .we(par_we), .waddr(par_wa), .wdata(par_wd), .raddr(par_ra), .rdata(par_rd));
  bmm_ram #(.DEPTH(DEPTH), .WIDTH(DW), .AW(VW)) u_dist (
    .clk, .we(dist_we), .waddr(dist_wa), .wdata(dist_wd), .raddr(dist_ra),
    .rdata(dist_rd));
  bmm_ram #(.DEPTH(DEPTH), .WIDTH(VW), .AW(VW)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
  bmm_ram #(.DEPTH(DEPTH), .WIDTH(2*VW), .AW(VW)) u_stack (
    .clk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (req.func)
            FUNC_ADD: if (add_ok) state_nxt = S_ADD_RA;
            FUNC_RUN: state_nxt = S_RUN_INIT;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_RA:    state_nxt = S_ADD_WA;
      S_ADD_WA:    state_nxt = S_ADD_RB;
      S_ADD_RB:    state_nxt = S_ADD_WB;
      S_ADD_WB:    state_nxt = S_IDLE;
      S_RUN_INIT:  state_nxt = S_L_START;
      S_L_START:   state_nxt = S_L_INIT_RD;
      S_L_INIT_RD: state_nxt = i_gt_n ? S_L_DIST0 : S_L_INIT_WR;
      S_L_INIT_WR: state_nxt = S_L_INIT_RD;
      S_L_DIST0:   state_nxt = S_L_POP;
      S_L_POP: begin
        if (!head_eq_tail)    state_nxt = S_L_POPD;
        else if (dist0_inf_r) state_nxt = S_EMIT;
        else                  state_nxt = S_A_NEXT;
      end
      S_L_POPD:    state_nxt = (q_rd == '0) ? S_L_POP : S_L_ROW;
      S_L_ROW:     state_nxt = S_L_SCAN;
      S_L_SCAN: begin
        if (v_gt_n)       state_nxt = S_L_POP;
        else if (row_bit) state_nxt = S_L_PW;
      end
      S_L_PW:      state_nxt = S_L_DW;
      S_L_DW:      state_nxt = S_L_SCAN;
      S_A_NEXT: begin
        if (!i_gt_n)       state_nxt = S_A_CHK;
        else if (gained_r) state_nxt = S_L_START;
        else               state_nxt = S_EMIT;
      end
      S_A_CHK:     state_nxt = (par_q == '0) ? S_A_LOAD : S_A_NEXT;
      S_A_LOAD:    state_nxt = S_A_ROW;
      S_A_ROW:     state_nxt = S_A_SCAN;
      S_A_SCAN: begin
        if (v_gt_n)       state_nxt = S_A_FAIL;
        else if (row_bit) state_nxt = S_A_PW;
      end
      S_A_PW:      state_nxt = S_A_DW;
      S_A_DW: begin
        if (!dist_hit)      state_nxt = S_A_SCAN;
        else if (w_r == '0) state_nxt = S_A_FLIP0;
        else if (can_push)  state_nxt = S_A_LOAD;
        else                state_nxt = S_A_SCAN;
      end
      S_A_FAIL:    state_nxt = top_zero ? S_A_NEXT : S_A_POPD;
      S_A_POPD:    state_nxt = S_A_LOAD;
      S_A_FLIP0:   state_nxt = S_A_FLIP1;
      S_A_FLIP1:   state_nxt = top_zero ? S_A_NEXT : S_A_FLIPD;
      S_A_FLIPD:   state_nxt = S_A_FLIP0;
      S_EMIT:      if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    i_nxt = i_r;  v_nxt = v_r;  head_nxt = head_r;  tail_nxt = tail_r;
    cur_next_nxt = cur_next_r;  top_nxt = top_r;  cur_u_nxt = cur_u_r;
    w_nxt = w_r;  a_nxt = a_r;  b_nxt = b_r;  row_nxt = row_r;  du_nxt = du_r;
    want_nxt = want_r;  dist0_inf_nxt = dist0_inf_r;  gained_nxt = gained_r;
    count_nxt = count_r;  adj_vld_nxt = adj_vld_r;  par_vld_nxt = par_vld_r;
    adj_we = 1'b0;  adj_wa = '0;  adj_wd = '0;  adj_ra = '0;
    par_we = 1'b0;  par_wa = '0;  par_wd = '0;  par_ra = '0;
    dist_we = 1'b0; dist_wa = '0; dist_wd = '0; dist_ra = '0;
    q_we = 1'b0;    q_wa = '0;    q_wd = '0;    q_ra = '0;
    st_we = 1'b0;   st_wa = '0;   st_wd = '0;   st_ra = '0;
    result_vld = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (req.func == FUNC_CLEAR) adj_vld_nxt = '0;
          a_nxt = a_ext[VW-1:0];
          b_nxt = b_ext[VW-1:0];
        end
      end
      S_ADD_RA: adj_ra = a_r;
      S_ADD_WA: begin
        adj_we = 1'b1;  adj_wa = a_r;
        adj_wd = adj_q | (DEPTH'(1) << b_r);
        adj_vld_nxt[a_r] = 1'b1;
      end
      S_ADD_RB: adj_ra = b_r;
      S_ADD_WB: begin
        adj_we = 1'b1;  adj_wa = b_r;
        adj_wd = adj_q | (DEPTH'(1) << a_r);
        adj_vld_nxt[b_r] = 1'b1;
      end
      S_RUN_INIT: begin
        par_vld_nxt = '0;
        count_nxt   = '0;
      end
      S_L_START: begin
        i_nxt = (VW+1)'(1);  head_nxt = '0;  tail_nxt = '0;
      end
      S_L_INIT_RD: par_ra = i_r[VW-1:0];
      S_L_INIT_WR: begin
        dist_we = 1'b1;  dist_wa = i_r[VW-1:0];
        dist_wd = (par_q == '0) ? '0 : DIST_INF;
        if (par_q == '0) begin
          q_we = 1'b1;  q_wa = tail_r[VW-1:0];  q_wd = i_r[VW-1:0];
          tail_nxt = tail_r + 1'b1;
        end
        i_nxt = i_r + 1'b1;
      end
      S_L_DIST0: begin
        dist_we = 1'b1;  dist_wa = '0;  dist_wd = DIST_INF;
        dist0_inf_nxt = 1'b1;
      end
      S_L_POP: begin
        q_ra = head_r[VW-1:0];
        if (!head_eq_tail) head_nxt = head_r + 1'b1;
        i_nxt = (VW+1)'(1);
        gained_nxt = 1'b0;
      end
      S_L_POPD: begin
        adj_ra = q_rd;  dist_ra = q_rd;
      end
      S_L_ROW: begin
        row_nxt = adj_q;  du_nxt = dist_rd;  v_nxt = (VW+1)'(1);
      end
      S_L_SCAN: begin
        par_ra = v_r[VW-1:0];
        if (!v_gt_n && !row_bit) v_nxt = v_r + 1'b1;
      end
      S_L_PW: begin
        w_nxt = par_q;  dist_ra = par_q;
      end
      S_L_DW: begin
        if (dist_rd == DIST_INF) begin
          dist_we = 1'b1;  dist_wa = w_r;  dist_wd = du_r + 1'b1;
          if (w_r == '0) dist0_inf_nxt = 1'b0;
          if (tail_r <= LIM_V) begin
            q_we = 1'b1;  q_wa = tail_r[VW-1:0];  q_wd = w_r;
            tail_nxt = tail_r + 1'b1;
          end
        end
        v_nxt = v_r + 1'b1;
      end
      S_A_NEXT: par_ra = i_r[VW-1:0];
      S_A_CHK: begin
        if (par_q == '0) begin
          cur_u_nxt = i_r[VW-1:0];  cur_next_nxt = (VW+1)'(1);  top_nxt = '0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_A_LOAD: begin
        adj_ra = cur_u_r;  dist_ra = cur_u_r;
      end
      S_A_ROW: begin
        row_nxt = adj_q;  want_nxt = {1'b0, dist_rd} + 1'b1;  v_nxt = cur_next_r;
      end
      S_A_SCAN: begin
        par_ra = v_r[VW-1:0];
        if (!v_gt_n && !row_bit) v_nxt = v_r + 1'b1;
      end
      S_A_PW: begin
        w_nxt = par_q;  dist_ra = par_q;
      end
      S_A_DW: begin
        if (!dist_hit) begin
          v_nxt = v_r + 1'b1;
        end else if (w_r != '0) begin
          if (can_push) begin
            st_we = 1'b1;  st_wa = top_r;  st_wd = {v_r[VW-1:0], cur_u_r};
            top_nxt = top_r + 1'b1;
            cur_u_nxt = w_r;  cur_next_nxt = (VW+1)'(1);
          end else begin
            v_nxt = v_r + 1'b1;
          end
        end
      end
      S_A_FAIL: begin
        dist_we = 1'b1;  dist_wa = cur_u_r;  dist_wd = DIST_INF;
        st_ra = top_r - 1'b1;
        if (top_zero) i_nxt = i_r + 1'b1;
        else          top_nxt = top_r - 1'b1;
      end
      S_A_POPD: begin
        cur_u_nxt = st_rd[VW-1:0];
        cur_next_nxt = {1'b0, st_rd[2*VW-1:VW]} + 1'b1;
      end
      S_A_FLIP0: begin
        par_we = 1'b1;  par_wa = v_r[VW-1:0];  par_wd = cur_u_r;
        par_vld_nxt[v_r[VW-1:0]] = 1'b1;
      end
      S_A_FLIP1: begin
        par_we = 1'b1;  par_wa = cur_u_r;  par_wd = v_r[VW-1:0];
        par_vld_nxt[cur_u_r] = 1'b1;
        st_ra = top_r - 1'b1;
        if (top_zero) begin
          if (count_r != COUNT_MAX) count_nxt = count_r + 1'b1;
          gained_nxt = 1'b1;
          i_nxt = i_r + 1'b1;
        end else begin
          top_nxt = top_r - 1'b1;
        end
      end
      S_A_FLIPD: begin
        cur_u_nxt = st_rd[VW-1:0];
        v_nxt = {1'b0, st_rd[2*VW-1:VW]};
      end
      S_EMIT: result_vld = out_free;
      default: ;
    endcase
  end

  assign idle   = (state_r == S_IDLE);
  assign result = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      adj_vld_r   <= '0;
      par_vld_r   <= '0;
      count_r     <= '0;
      gained_r    <= 1'b0;
      dist0_inf_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      adj_vld_r   <= adj_vld_nxt;
      par_vld_r   <= par_vld_nxt;
      count_r     <= count_nxt;
      gained_r    <= gained_nxt;
      dist0_inf_r <= dist0_inf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;  v_r <= v_nxt;  head_r <= head_nxt;  tail_r <= tail_nxt;
    cur_next_r <= cur_next_nxt;  top_r <= top_nxt;  cur_u_r <= cur_u_nxt;
    w_r <= w_nxt;  a_r <= a_nxt;  b_r <= b_nxt;  row_r <= row_nxt;
    du_r <= du_nxt;  want_r <= want_nxt;
    adj_rv_r <= adj_vld_r[adj_ra];
    par_rv_r <= par_vld_r[par_ra];
  end

endmodule

// ===== rtl/core/bipartite_max_matching.sv =====
// A clear empties the graph without leaving idle; a valid edge add reads and writes the
// rows of both endpoints; a run repeats phases of layering (setup, queue pops, edge scans)
// and augmenting (stack frames, edge tests, pair flips) until a phase finds no path.
// Throughput: one transaction at a time; a run holds in_tready low until its count
// is loaded into the output register, which may still wait on out_tready.
// Reset (rst_n low, synchronous) empties the graph, sets vertex_count to 1, drops results.
module bipartite_max_matching
  import bmm_pkg::*;
#(
  parameter int VERTEX_LIMIT = VERTEX_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // func[1:0], vertex_a[7:2], vertex_b[13:8], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // matching_size[4:0], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;

  logic [5:0] vertex_count_r;
  logic       out_valid_r;
  logic [4:0] out_data_r;
  logic       idle, result_vld, out_free;
  logic [4:0] result;
  bmm_req_t   req;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_VERTEX_COUNT) ? {26'd0, vertex_count_r} : 32'd0;

  assign req.func     = bmm_func_t'(in_tdata[1:0]);
  assign req.vertex_a = in_tdata[7:2];
  assign req.vertex_b = in_tdata[13:8];

  assign in_tready = idle;
  assign out_free  = !out_valid_r || out_tready;

  bmm_engine #(.VERTEX_LIMIT(VERTEX_LIMIT)) u_engine (
    .clk,
    .rst_n,
    .start(in_tvalid && in_tready),
    .req,
    .vertex_count(vertex_count_r),
    .out_free,
    .idle,
    .result_vld,
    .result
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= 6'd1;
      out_valid_r    <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_VERTEX_COUNT) begin
        vertex_count_r <= pwdata[5:0];
      end
      if (result_vld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_vld) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_data_r};

endmodule

// ===== rtl/core/bmm_checker.sv =====
// Port-level checks for the matching block and their binding.
module bmm_checker
  import bmm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // A pending result is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:5] == 3'd0)
    else $error("result padding not zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A run keeps the input closed at least for the following cycle.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] == FUNC_RUN |=> !in_tready)
    else $error("input open right after a run was taken");

endmodule

bind bipartite_max_matching bmm_checker u_bmm_checker (.*);

// ===== dv/bipartite_max_matching_tb.sv =====
// Self-checking testbench for the bipartite maximum matching engine.
`timescale 1ns / 100ps

module bipartite_max_matching_tb;
  import bmm_pkg::*;

  localparam int VMAX = 63;
  localparam int INF = 127;
  localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // func[1:0], vertex_a[7:2], vertex_b[13:8], zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // matching_size[4:0], zero pad
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bipartite_max_matching DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state.
  logic [63:0] graph_rows [0:63];
  int          mate [0:63];
  int          layer_dist [0:63];
  logic [5:0]  vcount_reg;

  bmm_req_t    pending_reqs [$];
  logic [4:0]  expected_sizes [$];
  int          send_idle_pct, recv_stall_pct;
  int          errors, results_seen, items_sent, runs_sent;

  function automatic bit layer_graph(int n);
    int q [$];
    int u, w;
    for (int i = 1; i <= n; i++) begin
      if (mate[i] == 0) begin
        layer_dist[i] = 0;
        q = {q, i};
      end else begin
        layer_dist[i] = INF;
      end
    end
    layer_dist[0] = INF;
    while (q.size() > 0) begin
      u = q.pop_front();
      if (u == 0) continue;
      for (int v = 1; v <= n; v++) begin
        if (!graph_rows[u][v]) continue;
        w = mate[v];
        if (layer_dist[w] == INF) begin
          layer_dist[w] = layer_dist[u] + 1;
          q = {q, w};
        end
      end
    end
    return layer_dist[0] != INF;
  endfunction

  function automatic bit augment_path(int start, int n);
    int sv [0:64];
    int sn [0:64];
    int top, u, want, found, w;
    top = 0;
    sv[0] = start;
    sn[0] = 1;
    forever begin
      u = sv[top];
      want = layer_dist[u] + 1;
      found = 0;
      for (int v = sn[top]; v <= n; v++) begin
        if (graph_rows[u][v] && layer_dist[mate[v]] == want) begin
          found = v;
          break;
        end
      end
      if (found == 0) begin
        layer_dist[u] = INF;
        if (top == 0) return 0;
        top--;
        continue;
      end
      sn[top] = found + 1;
      w = mate[found];
      if (w == 0) begin
        for (int k = top; k >= 0; k--) begin
          mate[sn[k] - 1] = sv[k];
          mate[sv[k]] = sn[k] - 1;
        end
        return 1;
      end
      if (top + 1 <= VMAX) begin
        top++;
        sv[top] = w;
        sn[top] = 1;
      end
    end
  endfunction

  function automatic logic [4:0] max_matching_size();
    int n, cnt;
    bit gained;
    n = vcount_reg;
    cnt = 0;
    for (int i = 0; i < 64; i++) begin
      mate[i] = 0;
      layer_dist[i] = 0;
    end
    while (layer_graph(n)) begin
      gained = 0;
      for (int i = 1; i <= n; i++) begin
        if (mate[i] == 0 && augment_path(i, n)) begin
          if (cnt < 31) cnt++;
          gained = 1;
        end
      end
      if (!gained) break;
    end
    return cnt[4:0];
  endfunction

  task automatic apply_request(bmm_req_t r);
    int a, b, n;
    logic [4:0] exp_size;
    a = r.vertex_a;
    b = r.vertex_b;
    n = vcount_reg;
    case (r.func)
      FUNC_CLEAR: for (int i = 0; i < 64; i++) graph_rows[i] = '0;
      FUNC_ADD: begin
        if (a != 0 && b != 0 && a <= n && b <= n && a != b) begin
          graph_rows[a][b] = 1'b1;
          graph_rows[b][a] = 1'b1;
        end
      end
      FUNC_RUN: begin
        exp_size = max_matching_size();
        expected_sizes = {expected_sizes, exp_size};
      end
      default: ;
    endcase
  endtask

  task automatic queue_req(bmm_req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata <= {2'b00, pending_reqs[0].vertex_b, pending_reqs[0].vertex_a,
                     pending_reqs[0].func};
        in_tvalid <= 1'b1;
        apply_request(pending_reqs.pop_front());
        items_sent++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor and stall generator.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_sizes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time,
                   out_tdata[4:0]);
          errors++;
        end else begin
          if (out_tdata[4:0] !== expected_sizes[0] || out_tdata[7:5] !== 3'b0) begin
            $display("%0t: matching_size mismatch, expected %0d, actual %0d", $time,
                     expected_sizes[0], out_tdata);
            errors++;
          end
          void'(expected_sizes.pop_front());
        end
      end
    end
  end

  task automatic write_vertex_count(logic [5:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_VERTEX_COUNT; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    vcount_reg = value;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_sizes.size() > 0 || in_tvalid)
      @(posedge clk);
    // A trailing add may still be busy inside the block.
    repeat (20) @(posedge clk);
  endtask

  function automatic bmm_req_t make_req(bmm_func_t f, int a, int b);
    bmm_req_t r;
    r.func = f;
    r.vertex_a = a[5:0];
    r.vertex_b = b[5:0];
    return r;
  endfunction

  // Mostly bipartite graph between the odd and even vertices, random content, some stray edges.
  task automatic queue_graph_and_run(int n, int edges);
    int a, b;
    queue_req(make_req(FUNC_CLEAR, $urandom, $urandom));
    for (int e = 0; e < edges; e++) begin
      a = $urandom_range(1, n);
      b = $urandom_range(1, n);
      if ($urandom_range(9) != 0 && (a % 2) == (b % 2)) b = (b < n) ? b + 1 : b - 1;
      if ($urandom_range(19) == 0) begin
        a = $urandom_range(63);
        b = $urandom_range(63);
      end
      queue_req(make_req(FUNC_ADD, a, b));
      items_sent += 0;
    end
    if ($urandom_range(9) == 0)
      queue_req(make_req(FUNC_NONE, $urandom, $urandom));
    queue_req(make_req(FUNC_RUN, $urandom, $urandom));
    runs_sent++;
  endtask

  initial begin
    int counts [6] = '{8, 1, 63, 0, 20, 12};
    int n;
    errors = 0; results_seen = 0; items_sent = 0; runs_sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    vcount_reg = 6'd1;
    for (int i = 0; i < 64; i++) graph_rows[i] = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset count of one, then a small graph with the special cases.
    queue_req(make_req(FUNC_ADD, 1, 1));
    queue_req(make_req(FUNC_RUN, 0, 0));
    wait_idle();
    write_vertex_count(6'd6);
    queue_req(make_req(FUNC_ADD, 1, 2));
    queue_req(make_req(FUNC_ADD, 3, 3));   // self loop
    queue_req(make_req(FUNC_ADD, 0, 2));   // nil endpoint
    queue_req(make_req(FUNC_ADD, 7, 2));   // beyond count
    queue_req(make_req(FUNC_ADD, 63, 63));
    queue_req(make_req(FUNC_ADD, 3, 2));
    queue_req(make_req(FUNC_ADD, 3, 4));
    queue_req(make_req(FUNC_ADD, 5, 6));
    queue_req(make_req(FUNC_ADD, 1, 4));
    queue_req(make_req(FUNC_NONE, 63, 63));
    queue_req(make_req(FUNC_RUN, 63, 63));
    queue_req(make_req(FUNC_ADD, 1, 3));   // odd cycle
    queue_req(make_req(FUNC_RUN, 0, 0));
    wait_idle();
    // Full count: a maximum matching of 31 pairs among 63 vertices reaches the top count of 31.
    write_vertex_count(6'd63);
    queue_req(make_req(FUNC_ADD, 62, 63));
    for (int i = 1; i < 62; i += 2) queue_req(make_req(FUNC_ADD, i, i + 1));
    queue_req(make_req(FUNC_RUN, 42, 21));
    wait_idle();
    // Smaller count: edges beyond it are left over and must be ignored.
    write_vertex_count(6'd5);
    queue_req(make_req(FUNC_RUN, 0, 0));
    wait_idle();
    write_vertex_count(6'd0);
    queue_req(make_req(FUNC_RUN, 0, 0));
    wait_idle();

    // Random phases with changing idle patterns and counts.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      write_vertex_count(counts[ph % 6][5:0]);
      n = (vcount_reg == 0) ? 1 : vcount_reg;
      for (int g = 0; g < 9; g++)
        queue_graph_and_run(n, (n > 30) ? $urandom_range(20, 30) : $urandom_range(2, 12));
      wait_idle();
    end
    wait_idle();
    $display("Sent %0d items including %0d random matching runs; %0d results checked.",
             items_sent, runs_sent, results_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

endmodule
